// ===== sv/rbe_pkg.sv =====
// rbe_pkg: shared types, constants and the month table for the rtc bcd to epoch converter
// no dependencies; imported by every module of the block
package rbe_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam int IN_DATA_W   = 48;
    localparam int OUT_DATA_W  = 40;
    localparam int EPOCH_W     = 33;
    localparam int ZONE_W      = 17;
    localparam int CFG_INDEX_W = 1;
    localparam int DAYS_W      = 16;
    localparam int DAY_SECS_W  = 32;
    localparam int TOD_W       = 20;
    localparam int SUM_W       = 34;

    localparam logic [CFG_INDEX_W-1:0] REG_CLOCK_IS_UTC = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_OFFSET  = 1'd1;

    localparam logic [7:0]  YEAR_BASE     = 8'd70;
    localparam logic [7:0]  CENTURY       = 8'd100;
    localparam logic [15:0] DAYS_PER_YEAR = 16'd365;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [19:0] SECS_PER_HOUR = 20'd3600;
    localparam logic [19:0] SECS_PER_MIN  = 20'd60;

    typedef struct packed {
        logic [DAYS_W-1:0] days;
        logic [7:0]        hour;
        logic [7:0]        minute;
        logic [7:0]        second;
    } item_t;

    typedef struct packed {
        logic              clock_is_utc;
        logic [ZONE_W-1:0] zone_offset;
    } cfg_t;

    function automatic logic [7:0] bcd_decode(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'b0, b[7:4]};
        return {4'b0, b[3:0]} + (hi << 3) + (hi << 1);
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] mi);
        logic [8:0] d;
        case (mi)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/rbe_front.sv =====
// rbe_front: accepts a request of six bcd bytes, decodes them and forms the day count
// depends on rbe_pkg
module rbe_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [rbe_pkg::IN_DATA_W-1:0] in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rbe_pkg::item_t                out_item
);
    import rbe_pkg::*;

    logic       valid_reg, valid_next;
    item_t      item_reg, item_next;

    logic [7:0] sec_dec, min_dec, hour_dec, day_dec, mon_dec, year_dec;
    logic [7:0] year_adj;
    logic [6:0] yofs;
    logic [7:0] yofs_inc;
    logic [3:0] mi;
    logic       leap;

    always_comb
    begin
        sec_dec  = bcd_decode(in_data[7:0]);
        min_dec  = bcd_decode(in_data[15:8]);
        hour_dec = bcd_decode(in_data[23:16]);
        day_dec  = bcd_decode(in_data[31:24]);
        mon_dec  = bcd_decode(in_data[39:32]);
        year_dec = bcd_decode(in_data[47:40]);

        year_adj = (year_dec < YEAR_BASE) ? year_dec + CENTURY : year_dec;
        yofs     = 7'(year_adj - YEAR_BASE);
        yofs_inc = {1'b0, yofs} + 8'd1;

        // month clamped into 1..12, kept as index 0..11
        if (mon_dec == 8'd0)
            mi = 4'd0;
        else if (mon_dec > 8'd12)
            mi = 4'd11;
        else
            mi = 4'(mon_dec - 8'd1);

        leap = (year_adj[1:0] == 2'b00) && (mi > 4'd1);

        item_next.days   = DAYS_W'(yofs) * DAYS_PER_YEAR
                         + DAYS_W'(yofs_inc >> 2)
                         + DAYS_W'(days_before_month(mi))
                         + DAYS_W'(leap)
                         + DAYS_W'(day_dec);
        item_next.hour   = hour_dec;
        item_next.minute = min_dec;
        item_next.second = sec_dec;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

// ===== sv/rbe_queue.sv =====
// rbe_queue: short register queue between the decode front and the arithmetic back
// depends on rbe_pkg
module rbe_queue #(
    parameter int DEPTH = rbe_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rbe_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output rbe_pkg::item_t out_item
);
    import rbe_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// ===== sv/rbe_back.sv =====
// rbe_back: scales the day count and time of day to seconds, applies the zone offset
// depends on rbe_pkg
module rbe_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rbe_pkg::cfg_t                  cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  rbe_pkg::item_t                 in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rbe_pkg::EPOCH_W-1:0]    out_epoch
);
    import rbe_pkg::*;

    logic                    s1_valid_reg, s1_valid_next;
    logic [DAY_SECS_W-1:0]   day_secs_reg, day_secs_next;
    logic [TOD_W-1:0]        tod_reg, tod_next;
    logic                    s2_valid_reg, s2_valid_next;
    logic [EPOCH_W-1:0]      epoch_reg, epoch_next;
    logic                    s1_en, s2_en;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] zone_ext;

    assign s2_en    = !s2_valid_reg || out_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_ready = s1_en;

    assign s1_valid_next = s1_en ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;

    always_comb
    begin
        day_secs_next = DAY_SECS_W'(in_item.days) * SECS_PER_DAY;
        tod_next      = TOD_W'(in_item.hour) * SECS_PER_HOUR
                      + TOD_W'(in_item.minute) * SECS_PER_MIN
                      + TOD_W'(in_item.second);
    end

    // day of month is 1 based, so one day comes off here
    always_comb
    begin
        zone_ext = cfg.clock_is_utc ? '0
                 : SUM_W'($signed(cfg.zone_offset));
        sum = $signed({2'b00, day_secs_reg})
            + $signed({{(SUM_W - TOD_W){1'b0}}, tod_reg})
            - $signed({2'b00, SECS_PER_DAY})
            + zone_ext;
        epoch_next = sum[EPOCH_W-1:0];
    end

    assign out_valid = s2_valid_reg;
    assign out_epoch = epoch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid)
        begin
            day_secs_reg <= day_secs_next;
            tod_reg      <= tod_next;
        end
        if (s2_en && s1_valid_reg)
            epoch_reg <= epoch_next;
    end

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_en |=> s1_valid_reg && $stable(day_secs_reg) && $stable(tod_reg))
        else $error("stage one lost or changed a held request");

    a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s2_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a request in stage one");

    a_take_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("taken request did not reach stage one");

endmodule

// ===== sv/rtc_bcd_to_epoch_seconds_core.sv =====
// rtc_bcd_to_epoch_seconds_core: top level, configuration registers and stream ports
// depends on rbe_pkg, rbe_front, rbe_queue, rbe_back
//
// Converts the six bcd bytes of a real-time clock (seconds, minutes, hours, day, month,
// two-digit year; years below 70 are 20xx) into signed 33-bit seconds since 1970, adding
// the configured zone offset when clock_is_utc is 0. One request is taken every cycle while
// m_tready does not stall the output; a result passes the decode register, a queue entry,
// the day-count times 86400 multiply register and the output register. Configuration
// writes take effect at once and are meant to be made while no request is in flight.
module rtc_bcd_to_epoch_seconds_core #(
    parameter int QUEUE_DEPTH = rbe_pkg::QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rbe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [rbe_pkg::ZONE_W-1:0]       cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // second_bcd, minute_bcd, hour_bcd, day_bcd, month_bcd, year_bcd
    input  logic [rbe_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // epoch_seconds, zero padding
    output logic [rbe_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import rbe_pkg::*;

    logic              clock_is_utc_reg, clock_is_utc_next;
    logic [ZONE_W-1:0] zone_offset_reg, zone_offset_next;
    cfg_t              cfg;

    logic              f_valid, f_ready;
    item_t             f_item;
    logic              q_valid, q_ready;
    item_t             q_item;
    logic [EPOCH_W-1:0] epoch;

    always_comb
    begin
        clock_is_utc_next = clock_is_utc_reg;
        zone_offset_next  = zone_offset_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CLOCK_IS_UTC: clock_is_utc_next = cfg_wdata[0];
                REG_ZONE_OFFSET:  zone_offset_next  = cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_is_utc_reg <= 1'b0;
            zone_offset_reg  <= '0;
        end
        else
        begin
            clock_is_utc_reg <= clock_is_utc_next;
            zone_offset_reg  <= zone_offset_next;
        end
    end

    assign cfg.clock_is_utc = clock_is_utc_reg;
    assign cfg.zone_offset  = zone_offset_reg;

    rbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    rbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    rbe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_item   (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_epoch (epoch)
    );

    assign m_tdata = {{(OUT_DATA_W - EPOCH_W){1'b0}}, epoch};

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// tb: stream-level testbench for rtc_bcd_to_epoch_seconds_core, bcd clock bytes in, epoch seconds out
// depends on rbe_pkg and the core; a scoreboard class predicts each result, plain tasks drive the ports
module tb;
    import rbe_pkg::*;

    localparam longint DAY_SECONDS   = 86400;
    localparam longint HOUR_SECONDS  = 3600;
    localparam longint MIN_SECONDS   = 60;
    localparam longint YEAR_SECONDS  = 31536000;
    localparam longint FIRST_YEAR    = 70;
    localparam int     PHASES        = 8;
    localparam int     PHASE_ITEMS   = 220;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     CYCLE_LIMIT   = 400000;

    class epoch_scoreboard;
        logic [EPOCH_W-1:0] pending_epochs[$];
        int                 errors;
        bit                 utc_mode;
        logic [ZONE_W-1:0]  zone;
        int                 month_start[12];

        function new();
            month_start = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
            errors      = 0;
            utc_mode    = 1'b0;
            zone        = '0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ZONE_W-1:0] value);
            if (idx == REG_CLOCK_IS_UTC)
                utc_mode = value[0];
            else
                zone = value;
        endfunction

        function longint unbcd(logic [7:0] b);
            return longint'(b[3:0]) + 10 * longint'(b[7:4]);
        endfunction

        function logic [EPOCH_W-1:0] epoch_of(logic [IN_DATA_W-1:0] d);
            longint sec;
            longint mins;
            longint hrs;
            longint dy;
            longint mon;
            longint yr;
            longint yofs;
            longint total;
            sec  = unbcd(d[7:0]);
            mins = unbcd(d[15:8]);
            hrs  = unbcd(d[23:16]);
            dy   = unbcd(d[31:24]);
            mon  = unbcd(d[39:32]);
            yr   = unbcd(d[47:40]);
            if (yr < FIRST_YEAR)
                yr += 100;
            if (mon < 1)
                mon = 1;
            if (mon > 12)
                mon = 12;
            yofs  = yr - FIRST_YEAR;
            total = yofs * YEAR_SECONDS + ((yofs + 1) / 4) * DAY_SECONDS;
            total += longint'(month_start[mon - 1]) * DAY_SECONDS;
            // leap day of the current year once february is over
            if ((yr % 4) == 0 && mon > 2)
                total += DAY_SECONDS;
            total += (dy - 1) * DAY_SECONDS + hrs * HOUR_SECONDS + mins * MIN_SECONDS + sec;
            if (!utc_mode)
                total += longint'($signed(zone));
            return total[EPOCH_W-1:0];
        endfunction

        function void note_request(logic [IN_DATA_W-1:0] d);
            pending_epochs.push_back(epoch_of(d));
        endfunction

        function void check_result(logic [EPOCH_W-1:0] got);
            logic [EPOCH_W-1:0] want;
            if (pending_epochs.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none actual %0d", $time, $signed(got));
                return;
            end
            want = pending_epochs.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t epoch_seconds mismatch: expected %0d actual %0d",
                         $time, $signed(want), $signed(got));
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ZONE_W-1:0]      cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    epoch_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int cycle_count   = 0;

    rtc_bcd_to_epoch_seconds_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random back-pressure, checked at the rising edge
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[EPOCH_W-1:0]);
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [ZONE_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(input logic [IN_DATA_W-1:0] data);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(data);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_results_done();
        while (sb.pending_epochs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [7:0] to_bcd(int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_request();
        logic [IN_DATA_W-1:0] d;
        int                   roll;
        int                   k;
        roll = $urandom_range(99);
        if (roll < 10)
            return IN_DATA_W'({$urandom, $urandom});
        d = {to_bcd($urandom_range(99)), to_bcd($urandom_range(1, 12)),
             to_bcd($urandom_range(1, 31)), to_bcd($urandom_range(23)),
             to_bcd($urandom_range(59)), to_bcd($urandom_range(59))};
        // corrupt one byte of an otherwise sane date
        if (roll < 30)
        begin
            k = $urandom_range(5);
            d[k*8 +: 8] = 8'($urandom_range(255));
        end
        return d;
    endfunction

    logic [IN_DATA_W-1:0] directed_requests[] = '{
        48'h70_01_01_00_00_00, 48'h69_12_31_23_59_59, 48'hff_ff_ff_ff_ff_ff,
        48'h00_00_00_00_00_00, 48'h00_02_29_00_00_00, 48'h00_03_01_00_00_00,
        48'h01_03_01_00_00_00, 48'h72_03_01_00_00_00, 48'h99_13_01_00_00_00,
        48'h99_1f_01_00_00_00, 48'h9a_06_15_00_00_00, 48'ha5_07_0b_0c_0f_0a,
        48'h70_01_00_00_00_00, 48'hbc_9a_78_56_34_12, 48'h99_12_31_00_00_00,
        48'h45_08_15_12_30_30, 48'h55_aa_55_aa_55_aa, 48'haa_55_aa_55_aa_55,
        48'h65_02_29_23_59_59, 48'h68_12_31_23_59_59
    };

    int phase_utc[PHASES]    = '{0, 0, 1, 0, 0, 1, 0, 0};
    int phase_offset[PHASES] = '{-50400, 50400, 12345, -65536, 65535, -1, 0, 0};

    initial
    begin
        int offset;
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_requests[i])
            send_request(directed_requests[i]);
        stop_sending();
        wait_results_done();

        for (int p = 0; p < PHASES; p++)
        begin
            offset = phase_offset[p];
            if (p == PHASES - 2)
                offset = int'($urandom_range(100800)) - 50400;
            write_reg(REG_CLOCK_IS_UTC, ZONE_W'(phase_utc[p]));
            write_reg(REG_ZONE_OFFSET, ZONE_W'(offset));
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 84;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 84;
                end
                default:
                begin
                    send_idle_pct = 34;
                    stall_pct     = 34;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // hold off mid-phase until the pipe is empty
                if (p == 3 && i == PHASE_ITEMS / 2)
                begin
                    stop_sending();
                    while (sb.pending_epochs.size() != 0)
                        @(posedge clk);
                end
                send_request(random_request());
            end
            stop_sending();
            wait_results_done();
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
